// File: src/smbios_chassis_type_finder_unit_defines.svh
// ----------------------------------------------------------------------------
// SMBIOS chassis type finder: assertion macros
// Concurrent assertion helpers, compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SMBIOS_CHASSIS_TYPE_FINDER_UNIT_DEFINES_SVH
`define SMBIOS_CHASSIS_TYPE_FINDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SCTF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sctf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SCTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sctf: next-cycle check failed");

`else

`define SCTF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define SCTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: src/sctf_pkg.sv
// ----------------------------------------------------------------------------
// SMBIOS chassis type finder package
// Types, constants and the chassis form classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sctf_pkg;

    // Parser phase within one table.
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_STRINGS = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    // Form class reported alongside the chassis type.
    typedef enum logic [2:0] {
        FC_UNKNOWN  = 3'd0,
        FC_LAPTOP   = 3'd1,
        FC_TABLET   = 3'd2,
        FC_DESKTOP  = 3'd3,
        FC_SERVER   = 3'd4,
        FC_EMBEDDED = 3'd5
    } t_form_class;

    localparam logic [7:0] TYPE_END          = 8'd127;
    localparam logic [7:0] TYPE_ENCLOSURE    = 8'd3;
    localparam logic [7:0] MIN_LENGTH        = 8'd4;
    localparam logic [7:0] ENC_MIN_LENGTH    = 8'd5;  // length must exceed this
    localparam logic [7:0] CHASSIS_OFFSET    = 8'd5;
    localparam logic [7:0] CHASSIS_LAST_CODE = 8'd36;

    function automatic t_form_class form_of(input logic [7:0] t);
        t_form_class fc;
        fc = FC_UNKNOWN;
        if (t == 8'd8 || t == 8'd9 || t == 8'd10 || t == 8'd14) begin
            fc = FC_LAPTOP;
        end else if (t == 8'd11 || (t >= 8'd30 && t <= 8'd32)) begin
            fc = FC_TABLET;
        end else if ((t >= 8'd3 && t <= 8'd7) || t == 8'd13 || t == 8'd15 ||
                     t == 8'd16 || t == 8'd24) begin
            fc = FC_DESKTOP;
        end else if ((t >= 8'd17 && t <= 8'd23) || (t >= 8'd25 && t <= 8'd29)) begin
            fc = FC_SERVER;
        end else if (t >= 8'd33 && t <= CHASSIS_LAST_CODE) begin
            fc = FC_EMBEDDED;
        end
        return fc;
    endfunction

endpackage

`default_nettype wire

// File: src/smbios_chassis_type_finder_unit.sv
// ----------------------------------------------------------------------------
// SMBIOS chassis type finder unit
// Walks an SMBIOS structure table byte by byte and reports the enclosure
// chassis type and its form class, one result transaction per table.
// ----------------------------------------------------------------------------
// The unit takes one table byte per input transaction, at a sustained rate of
// one byte per clock cycle while results are taken, and gives exactly one result
// transaction per table. Each byte is handled in the cycle it is accepted by
// a short walk update (a few compares and an 8-bit increment), and any result
// goes into a single output register. A result appears on the output in the
// cycle after the byte that caused it: either byte 5 of the first enclosure
// structure (type 3, length over 5), or the byte flagged as last when no
// enclosure was found, in which case the chassis type is 0 and the class is
// unknown. The input stays ready while a result waits, as long as the result
// is being taken in the same cycle; only an untaken result stalls the input.
`timescale 1ns / 1ps
`default_nettype none
`include "smbios_chassis_type_finder_unit_defines.svh"

module smbios_chassis_type_finder_unit
    import sctf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Table byte input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    // Result output channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_enclosure_type,
    output logic [2:0]      o_form_class
);

    // Walk state.
    t_phase      r_phase,      n_phase;
    logic [7:0]  r_hdr_off,    n_hdr_off;
    logic [7:0]  r_len,        n_len;
    logic        r_is_enc,     n_is_enc;
    logic        r_prev_zero,  n_prev_zero;
    logic        r_answered,   n_answered;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_enc_type;
    t_form_class r_form;

    logic        in_fire;
    logic        hit;
    logic        miss;
    logic [7:0]  off_inc;

    // The input may move whenever the result slot is empty or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign off_inc    = r_hdr_off + 8'd1;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_off   = r_hdr_off;
        n_len       = r_len;
        n_is_enc    = r_is_enc;
        n_prev_zero = r_prev_zero;
        n_answered  = r_answered;
        hit         = 1'b0;
        miss        = 1'b0;
        if (in_fire) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_off == 8'd0) begin
                        // Type byte: the end-of-table type stops the walk.
                        if (i_data_byte == TYPE_END) begin
                            n_phase = PH_DONE;
                        end
                        n_is_enc = (i_data_byte == TYPE_ENCLOSURE);
                    end else if (r_hdr_off == 8'd1) begin
                        // Length byte: too short a structure stops the walk.
                        n_len = i_data_byte;
                        if (i_data_byte < MIN_LENGTH) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_is_enc = r_is_enc && (i_data_byte > ENC_MIN_LENGTH);
                        end
                    end else if (r_hdr_off == CHASSIS_OFFSET && r_is_enc) begin
                        hit        = 1'b1;
                        n_answered = 1'b1;
                        n_phase    = PH_DONE;
                    end
                    if (n_phase == PH_HEADER) begin
                        // The formatted area ends once the offset reaches the length.
                        if (r_hdr_off != 8'd0 && off_inc >= n_len) begin
                            n_phase     = PH_STRINGS;
                            n_prev_zero = 1'b0;
                            n_hdr_off   = 8'd0;
                        end else begin
                            n_hdr_off = off_inc;
                        end
                    end
                end
                PH_STRINGS: begin
                    // A double zero closes the string set.
                    if (r_prev_zero && i_data_byte == 8'd0) begin
                        n_phase     = PH_HEADER;
                        n_hdr_off   = 8'd0;
                        n_len       = 8'd0;
                        n_is_enc    = 1'b0;
                        n_prev_zero = 1'b0;
                    end else begin
                        n_prev_zero = (i_data_byte == 8'd0);
                    end
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase
            // The last byte closes the table and rearms the walk.
            if (i_last_byte) begin
                miss        = !n_answered;
                n_phase     = PH_HEADER;
                n_hdr_off   = 8'd0;
                n_len       = 8'd0;
                n_is_enc    = 1'b0;
                n_prev_zero = 1'b0;
                n_answered  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_off   <= 8'd0;
            r_len       <= 8'd0;
            r_is_enc    <= 1'b0;
            r_prev_zero <= 1'b0;
            r_answered  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_off   <= n_hdr_off;
            r_len       <= n_len;
            r_is_enc    <= n_is_enc;
            r_prev_zero <= n_prev_zero;
            r_answered  <= n_answered;
        end
    end

    // Result valid: set by a new result, cleared when the result is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (hit || miss) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            r_enc_type <= i_data_byte;
            r_form     <= form_of(i_data_byte);
        end else if (miss) begin
            r_enc_type <= 8'd0;
            r_form     <= FC_UNKNOWN;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_enclosure_type = r_enc_type;
    assign o_form_class     = r_form;

    // An answer always parks the walk until the table ends.
    `SCTF_ASSERT_IMPLIES(a_answered_parks, i_clk, i_rst_n, r_answered, r_phase == PH_DONE)
    // A table end that was not answered earlier leaves a result waiting in the next cycle.
    `SCTF_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, in_fire && i_last_byte && !r_answered, r_out_valid)
    // Every table end rearms the walk.
    `SCTF_ASSERT_NEXT(a_last_rearms, i_clk, i_rst_n, in_fire && i_last_byte, r_phase == PH_HEADER && r_hdr_off == 8'd0 && !r_answered)
    // A result of unknown type never carries a known class.
    `SCTF_ASSERT_IMPLIES(a_zero_unknown, i_clk, i_rst_n, r_out_valid && r_enc_type == 8'd0, r_form == FC_UNKNOWN)

endmodule

`default_nettype wire

// File: tb/sctf_result_checker.sv
// ----------------------------------------------------------------------------
// SMBIOS chassis type finder result checker
// Watches both channels, runs its own table walk on every accepted byte and
// compares each result transaction with the oldest expected chassis result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sctf_result_checker
    import sctf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic [7:0] i_enclosure_type,
    input  wire logic [2:0] i_form_class,
    output int              o_fail_count,
    output int              o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]  chassis;
        t_form_class form;
    } t_chassis_result;

    t_chassis_result pending_chassis[$];

    // Walk state of the table being predicted.
    t_phase     walk_phase;
    logic [7:0] hdr_index;
    logic [7:0] fmt_length;
    logic       enc_seen;
    logic       zero_seen;
    logic       table_answered;

    int fail_count = 0;

    function automatic t_form_class chassis_form(input logic [7:0] code);
        t_form_class fc;
        case (code)
            8'd8, 8'd9, 8'd10, 8'd14:                      fc = FC_LAPTOP;
            8'd11, 8'd30, 8'd31, 8'd32:                    fc = FC_TABLET;
            8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd13, 8'd15,
            8'd16, 8'd24:                                  fc = FC_DESKTOP;
            8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
            8'd25, 8'd26, 8'd27, 8'd28, 8'd29:             fc = FC_SERVER;
            8'd33, 8'd34, 8'd35, 8'd36:                    fc = FC_EMBEDDED;
            default:                                       fc = FC_UNKNOWN;
        endcase
        return fc;
    endfunction

    task automatic restart_walk();
        walk_phase     = PH_HEADER;
        hdr_index      = 8'd0;
        fmt_length     = 8'd0;
        enc_seen       = 1'b0;
        zero_seen      = 1'b0;
        table_answered = 1'b0;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic fin);
        logic [7:0]      idx;
        logic [7:0]      idx_next;
        t_chassis_result found;
        idx      = hdr_index;
        idx_next = idx + 8'd1;
        case (walk_phase)
            PH_HEADER: begin
                if (idx == 8'd0) begin
                    if (b == TYPE_END) begin
                        walk_phase = PH_DONE;
                    end
                    enc_seen = (b == TYPE_ENCLOSURE);
                end else if (idx == 8'd1) begin
                    fmt_length = b;
                    if (b < MIN_LENGTH) begin
                        walk_phase = PH_DONE;
                    end else begin
                        enc_seen = enc_seen && (b > ENC_MIN_LENGTH);
                    end
                end else if (idx == CHASSIS_OFFSET && enc_seen) begin
                    found.chassis  = b;
                    found.form     = chassis_form(b);
                    pending_chassis.push_back(found);
                    table_answered = 1'b1;
                    walk_phase     = PH_DONE;
                end
                if (walk_phase == PH_HEADER) begin
                    if (idx != 8'd0 && idx_next >= fmt_length) begin
                        walk_phase = PH_STRINGS;
                        zero_seen  = 1'b0;
                        hdr_index  = 8'd0;
                    end else begin
                        hdr_index = idx_next;
                    end
                end
            end
            PH_STRINGS: begin
                // A second zero in a row closes the string set.
                if (zero_seen && b == 8'd0) begin
                    walk_phase = PH_HEADER;
                    hdr_index  = 8'd0;
                    fmt_length = 8'd0;
                    enc_seen   = 1'b0;
                    zero_seen  = 1'b0;
                end else begin
                    zero_seen = (b == 8'd0);
                end
            end
            default: begin
            end
        endcase
        if (fin) begin
            if (!table_answered) begin
                found.chassis = 8'd0;
                found.form    = FC_UNKNOWN;
                pending_chassis.push_back(found);
            end
            restart_walk();
        end
    endtask

    task automatic note_failure(input string what, input t_chassis_result want);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected type %0d class %0d, got type %0d class %0d",
                     $realtime, what, want.chassis, want.form,
                     i_enclosure_type, i_form_class);
        end
    endtask

    always @(posedge i_clk) begin
        t_chassis_result want;
        if (!i_rst_n) begin
            restart_walk();
            pending_chassis.delete();
        end else begin
            // Results leave before the byte taken at the same edge is walked.
            if (i_out_valid && i_out_ready) begin
                if (pending_chassis.size() == 0) begin
                    want = '0;
                    note_failure("unexpected result", want);
                end else begin
                    want = pending_chassis.pop_front();
                    if (i_enclosure_type !== want.chassis ||
                        i_form_class !== 3'(want.form)) begin
                        note_failure("result mismatch", want);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                walk_byte(i_data_byte, i_last_byte);
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= pending_chassis.size();
    end

endmodule

`default_nettype wire

// File: tb/smbios_chassis_type_finder_unit_tb.sv
// ----------------------------------------------------------------------------
// SMBIOS chassis type finder unit testbench
// Feeds structure tables byte by byte, first a few hand-built ones and then
// randomly shaped ones, under changing back-pressure, and lets the result
// checker judge every result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smbios_chassis_type_finder_unit_tb;
    import sctf_pkg::*;

    // The limit leaves ample room for the heaviest stalls on both channels.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1650;
    // Bytes sent in each of the first two back-pressure phases.
    localparam int PHASE_ITEMS  = 560;
    // The result register fills in the cycle after the byte, so the drain wait is
    // plenty to catch any stray result transaction at the end.
    localparam int DRAIN_CYCLES = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_enclosure_type;
    logic [2:0] o_form_class;

    int fail_count;
    int outstanding;
    int cycle_count;
    int items_sent;
    int tx_idle_pct;
    int rx_idle_pct;

    // Bytes of the table about to be sent.
    logic [7:0] image_bytes[$];

    smbios_chassis_type_finder_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_enclosure_type (o_enclosure_type),
        .o_form_class     (o_form_class)
    );

    sctf_result_checker u_result_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_enclosure_type (o_enclosure_type),
        .i_form_class     (o_form_class),
        .o_fail_count     (fail_count),
        .o_outstanding    (outstanding)
    );

    // 2 ns clock period.
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Watchdog: a hung handshake or a result that never arrives ends up here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("smbios_chassis_type_finder_unit_tb: FAIL");
            $finish;
        end
    end

    // The result side refuses transactions at random, at the rate set by the
    // current phase of the run.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Offers one byte, after a random number of idle cycles, and holds it
    // until the transaction is accepted. The back-pressure phase follows the
    // number of bytes already sent: the sender idles lightly while the
    // receiver stalls heavily, then the roles swap, then neither side idles.
    task automatic push_byte(input logic [7:0] b, input logic fin);
        if (items_sent < PHASE_ITEMS) begin
            tx_idle_pct = 21;
            rx_idle_pct = 56;
        end else if (items_sent < 2 * PHASE_ITEMS) begin
            tx_idle_pct = 56;
            rx_idle_pct = 21;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Sends the whole table, with the last flag on its final byte.
    task automatic send_image();
        for (int k = 0; k < image_bytes.size(); k++) begin
            push_byte(image_bytes[k], k == image_bytes.size() - 1);
        end
    endtask

    // Builds a random table. Most tables are well-formed chains of structures
    // so that the walk gets past the headers and into the string sets; a few
    // are plain noise, and some are cut short at a random byte.
    task automatic build_random_image();
        int         shape;
        int         pick;
        int         fmt_len;
        int         n_str;
        int         cut;
        logic [7:0] kind_byte;
        image_bytes.delete();
        shape = $urandom_range(0, 99);
        if (shape < 8) begin
            repeat ($urandom_range(1, 24)) image_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 4)) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    kind_byte = TYPE_ENCLOSURE;
                    fmt_len   = $urandom_range(6, 14);
                end else if (pick < 48) begin
                    // An enclosure too short to carry a chassis byte.
                    kind_byte = TYPE_ENCLOSURE;
                    fmt_len   = $urandom_range(4, 5);
                end else if (pick < 53) begin
                    kind_byte = TYPE_END;
                    fmt_len   = 4;
                end else begin
                    kind_byte = 8'($urandom);
                    fmt_len   = $urandom_range(4, 20);
                end
                // Now and then a length too short to be legal, and rarely a
                // very long formatted area.
                if ($urandom_range(0, 99) < 5) begin
                    fmt_len = $urandom_range(0, 3);
                end else if ($urandom_range(0, 99) < 2) begin
                    fmt_len = $urandom_range(200, 255);
                end
                image_bytes.push_back(kind_byte);
                image_bytes.push_back(8'(fmt_len));
                for (int i = 2; i < fmt_len; i++) begin
                    if (i == CHASSIS_OFFSET && $urandom_range(0, 99) < 75) begin
                        // Mostly codes around the listed range, so that every
                        // form class turns up.
                        image_bytes.push_back(8'($urandom_range(0, 40)));
                    end else if ($urandom_range(0, 3) == 0) begin
                        // Zeros in the formatted area must not end anything.
                        image_bytes.push_back(8'd0);
                    end else begin
                        image_bytes.push_back(8'($urandom));
                    end
                end
                n_str = $urandom_range(0, 3);
                repeat (n_str) begin
                    repeat ($urandom_range(1, 6)) begin
                        image_bytes.push_back(8'($urandom_range(1, 255)));
                    end
                    image_bytes.push_back(8'd0);
                end
                // An empty string set is two zeros; otherwise one more zero
                // closes the set.
                image_bytes.push_back(8'd0);
                if (n_str == 0) begin
                    image_bytes.push_back(8'd0);
                end
            end
            // Bytes after the answer or the end marker are simply ignored.
            if ($urandom_range(0, 99) < 30) begin
                repeat ($urandom_range(1, 8)) image_bytes.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, image_bytes.size());
            while (image_bytes.size() > cut) begin
                void'(image_bytes.pop_back());
            end
        end
    endtask

    initial begin
        int random_target;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'd0;
        i_last_byte <= 1'b0;
        items_sent  = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Enclosure whose chassis byte is the last listed code, arriving on
        // the final byte of the table.
        image_bytes = '{TYPE_ENCLOSURE, 8'd6, 8'd0, 8'd0, 8'd0, CHASSIS_LAST_CODE};
        send_image();
        // End marker straight away: no chassis found.
        image_bytes = '{TYPE_END};
        send_image();
        // Illegal short length stops the walk.
        image_bytes = '{8'd1, 8'd3};
        send_image();
        // Table ends before the chassis byte of an enclosure.
        image_bytes = '{TYPE_ENCLOSURE, 8'd8, 8'd0, 8'd0};
        send_image();
        // Unlisted chassis code, followed by bytes that must be ignored.
        image_bytes = '{TYPE_ENCLOSURE, 8'd6, 8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'd0, 8'd9};
        send_image();

        random_target = items_sent + RANDOM_ITEMS;
        while (items_sent < random_target) begin
            build_random_image();
            send_image();
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        // Wait for every expected result, then a little longer to catch any
        // extra transaction from the block.
        while (outstanding != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("smbios_chassis_type_finder_unit_tb: PASS");
        end else begin
            $display("smbios_chassis_type_finder_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
